/* sv/fpa_pkg.sv */
package fpa_pkg;

  localparam int DEF_WORD_BITS      = 32;
  localparam int DEF_FRACTION_WIDTH = 8;
  localparam int DIV_STEPS          = 8;
  localparam int OUT_BITS           = 32;

  typedef enum logic [3:0] {
    FN_ADD      = 4'd0,
    FN_SUB      = 4'd1,
    FN_MUL      = 4'd2,
    FN_DIV      = 4'd3,
    FN_GT       = 4'd4,
    FN_LT       = 4'd5,
    FN_GE       = 4'd6,
    FN_LE       = 4'd7,
    FN_EQ       = 4'd8,
    FN_NE       = 4'd9,
    FN_MIN      = 4'd10,
    FN_MAX      = 4'd11,
    FN_INC      = 4'd12,
    FN_DEC      = 4'd13,
    FN_FROM_INT = 4'd14,
    FN_TO_INT   = 4'd15
  } func_t;

endpackage

/* sv/fpa_div_stage.sv */
module fpa_div_stage #(
  parameter int WORD_BITS = fpa_pkg::DEF_WORD_BITS,
  parameter int NUM_BITS  = fpa_pkg::DEF_WORD_BITS + fpa_pkg::DEF_FRACTION_WIDTH,
  parameter int STEPS     = fpa_pkg::DIV_STEPS
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [WORD_BITS-1:0] den_in,
  input  logic [WORD_BITS-1:0] rem_in,
  input  logic [NUM_BITS-1:0]  num_in,
  input  logic [WORD_BITS-1:0] quo_in,
  output logic [WORD_BITS-1:0] den_out,
  output logic [WORD_BITS-1:0] rem_out,
  output logic [NUM_BITS-1:0]  num_out,
  output logic [WORD_BITS-1:0] quo_out
);

  logic [WORD_BITS-1:0] rem_next;
  logic [NUM_BITS-1:0]  num_next;
  logic [WORD_BITS-1:0] quo_next;

  // Restoring division, one quotient bit per step.
  always_comb begin
    logic [WORD_BITS:0] r;
    logic [NUM_BITS-1:0] n;
    logic [WORD_BITS-1:0] q;
    r = {1'b0, rem_in};
    n = num_in;
    q = quo_in;
    for (int k = 0; k < STEPS; k++) begin
      r = {r[WORD_BITS-1:0], n[NUM_BITS-1]};
      n = {n[NUM_BITS-2:0], 1'b0};
      if (r >= {1'b0, den_in}) begin
        r = r - {1'b0, den_in};
        q = {q[WORD_BITS-2:0], 1'b1};
      end else begin
        q = {q[WORD_BITS-2:0], 1'b0};
      end
    end
    rem_next = r[WORD_BITS-1:0];
    num_next = n;
    quo_next = q;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_out <= den_in;
      rem_out <= rem_next;
      num_out <= num_next;
      quo_out <= quo_next;
    end
  end

endmodule

/* sv/fixed_point_alu_unit.sv */
// Signed fixed-point ALU, fully pipelined.
// The pipeline registers the inputs, then passes them through the divider stages and an output register;
// the depth is set by the restoring divider, which resolves up to 8 quotient bits per stage.
// Throughput: one word per cycle; the whole pipeline holds while the output is stalled.
// Reset clears only the valid bits; the pipeline is empty and ready after reset.
module fixed_point_alu_unit #(
  parameter int WORD_BITS      = fpa_pkg::DEF_WORD_BITS,
  parameter int FRACTION_WIDTH = fpa_pkg::DEF_FRACTION_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [3:0]                         func,
  input  logic signed [31:0]                 operand_a,
  input  logic signed [31:0]                 operand_b,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [fpa_pkg::OUT_BITS-1:0] result_value,
  output logic                               compare_true,
  output logic                               divide_by_zero
);

  localparam int NUM_BITS = WORD_BITS + FRACTION_WIDTH;
  localparam int NSTG     = (NUM_BITS + fpa_pkg::DIV_STEPS - 1) / fpa_pkg::DIV_STEPS;

  logic en;
  logic [NSTG+1:0] vld;

  // Sideband that rides alongside the divider: index 0 is the input stage.
  fpa_pkg::func_t              sb_func [NSTG+1];
  logic signed [WORD_BITS-1:0] sb_res  [NSTG+1];
  logic                        sb_cmp  [NSTG+1];
  logic                        sb_neg  [NSTG+1];
  logic                        sb_bz   [NSTG+1];
  logic signed [WORD_BITS-1:0] prod    [NSTG];

  logic [WORD_BITS-1:0] den [NSTG+1];
  logic [WORD_BITS-1:0] rem [NSTG+1];
  logic [NUM_BITS-1:0]  num [NSTG+1];
  logic [WORD_BITS-1:0] quo [NSTG+1];

  logic signed [WORD_BITS-1:0] a_w, b_w, res_next;
  logic [WORD_BITS-1:0]        ua, ub;
  logic                        lt_ab, lt_ba, cmp_next;
  fpa_pkg::func_t              fn;
  logic signed [2*WORD_BITS-1:0] mul_full;
  logic signed [WORD_BITS-1:0] quo_s, final_res;

  assign en        = !vld[NSTG+1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[NSTG+1];

  assign fn    = fpa_pkg::func_t'(func);
  assign a_w   = WORD_BITS'(operand_a);
  assign b_w   = WORD_BITS'(operand_b);
  assign ua    = a_w[WORD_BITS-1] ? WORD_BITS'(-a_w) : a_w;
  assign ub    = b_w[WORD_BITS-1] ? WORD_BITS'(-b_w) : b_w;
  assign lt_ab = a_w < b_w;
  assign lt_ba = b_w < a_w;

  always_comb begin
    res_next = '0;
    cmp_next = 1'b0;
    unique case (fn)
      fpa_pkg::FN_ADD:      res_next = a_w + b_w;
      fpa_pkg::FN_SUB:      res_next = a_w - b_w;
      fpa_pkg::FN_MUL:      res_next = '0;
      fpa_pkg::FN_DIV:      res_next = '0;
      fpa_pkg::FN_GT:       cmp_next = lt_ba;
      fpa_pkg::FN_LT:       cmp_next = lt_ab;
      fpa_pkg::FN_GE:       cmp_next = !lt_ab;
      fpa_pkg::FN_LE:       cmp_next = !lt_ba;
      fpa_pkg::FN_EQ:       cmp_next = (a_w == b_w);
      fpa_pkg::FN_NE:       cmp_next = (a_w != b_w);
      fpa_pkg::FN_MIN:      res_next = lt_ab ? a_w : b_w;
      fpa_pkg::FN_MAX:      res_next = lt_ba ? a_w : b_w;
      fpa_pkg::FN_INC:      res_next = a_w + WORD_BITS'(1);
      fpa_pkg::FN_DEC:      res_next = a_w - WORD_BITS'(1);
      fpa_pkg::FN_FROM_INT: res_next = a_w <<< FRACTION_WIDTH;
      fpa_pkg::FN_TO_INT:   res_next = a_w >>> FRACTION_WIDTH;
      default:              res_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTG:0], in_valid};
    end
  end

  logic signed [WORD_BITS-1:0] a_s1, b_s1;

  always_ff @(posedge clk) begin
    if (en) begin
      sb_func[0] <= fn;
      sb_res[0]  <= res_next;
      sb_cmp[0]  <= cmp_next;
      sb_neg[0]  <= a_w[WORD_BITS-1] ^ b_w[WORD_BITS-1];
      sb_bz[0]   <= (b_w == '0);
      a_s1       <= a_w;
      b_s1       <= b_w;
      den[0]     <= ub;
      rem[0]     <= '0;
      num[0]     <= {ua, {FRACTION_WIDTH{1'b0}}};
      quo[0]     <= '0;
    end
  end

  assign mul_full = a_s1 * b_s1;

  genvar g;
  generate
    for (g = 0; g < NSTG; g++) begin : g_div
      localparam int LEFT  = NUM_BITS - g * fpa_pkg::DIV_STEPS;
      localparam int STEPS = (LEFT < fpa_pkg::DIV_STEPS) ? LEFT : fpa_pkg::DIV_STEPS;

      fpa_div_stage #(
        .WORD_BITS(WORD_BITS),
        .NUM_BITS (NUM_BITS),
        .STEPS    (STEPS)
      ) u_stage (
        .clk    (clk),
        .en     (en),
        .den_in (den[g]),
        .rem_in (rem[g]),
        .num_in (num[g]),
        .quo_in (quo[g]),
        .den_out(den[g+1]),
        .rem_out(rem[g+1]),
        .num_out(num[g+1]),
        .quo_out(quo[g+1])
      );

      always_ff @(posedge clk) begin
        if (en) begin
          sb_func[g+1] <= sb_func[g];
          sb_res[g+1]  <= sb_res[g];
          sb_cmp[g+1]  <= sb_cmp[g];
          sb_neg[g+1]  <= sb_neg[g];
          sb_bz[g+1]   <= sb_bz[g];
        end
      end

      if (g == 0) begin : g_mul
        always_ff @(posedge clk) begin
          if (en) begin
            prod[0] <= mul_full[FRACTION_WIDTH +: WORD_BITS];
          end
        end
      end else begin : g_carry
        always_ff @(posedge clk) begin
          if (en) begin
            prod[g] <= prod[g-1];
          end
        end
      end
    end
  endgenerate

  assign quo_s = sb_neg[NSTG] ? WORD_BITS'(-quo[NSTG]) : quo[NSTG];

  always_comb begin
    if (sb_func[NSTG] == fpa_pkg::FN_DIV) begin
      final_res = sb_bz[NSTG] ? '0 : quo_s;
    end else if (sb_func[NSTG] == fpa_pkg::FN_MUL) begin
      final_res = prod[NSTG-1];
    end else begin
      final_res = sb_res[NSTG];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result_value   <= fpa_pkg::OUT_BITS'(final_res);
      compare_true   <= sb_cmp[NSTG];
      divide_by_zero <= (sb_func[NSTG] == fpa_pkg::FN_DIV) && sb_bz[NSTG];
    end
  end

endmodule

/* tb/tb_fixed_point_alu_unit.sv */
module tb_fixed_point_alu_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = fpa_pkg::DEF_FRACTION_WIDTH;
  localparam int LATENCY = 7;
  localparam int N_RANDOM = 2000;

  typedef struct packed {
    logic signed [31:0] value;
    logic               cmp;
    logic               dz;
  } alu_result_t;

  typedef struct {
    fpa_pkg::func_t     fn;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic               known;
    alu_result_t        res;
  } vector_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [3:0] func = '0;
  logic signed [31:0] operand_a = '0;
  logic signed [31:0] operand_b = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] result_value;
  logic compare_true;
  logic divide_by_zero;

  alu_result_t pending_results[$];
  vector_t vectors[$];
  int errors = 0;

  fixed_point_alu_unit dut (.*);

  always #2 clk = ~clk;

  function automatic alu_result_t alu_predict(fpa_pkg::func_t fn, logic signed [31:0] a,
                                              logic signed [31:0] b);
    alu_result_t r;
    logic signed [63:0] prod;
    logic signed [63:0] num;
    logic signed [63:0] quo;
    r = '0;
    case (fn)
      fpa_pkg::FN_ADD: r.value = a + b;
      fpa_pkg::FN_SUB: r.value = a - b;
      fpa_pkg::FN_MUL: begin
        prod = 64'(a) * 64'(b);
        r.value = 32'(prod >>> FRAC);
      end
      fpa_pkg::FN_DIV: begin
        if (b == 0) begin
          r.dz = 1'b1;
        end else begin
          // Widened dividend; SV division truncates toward zero.
          num = 64'(a) <<< FRAC;
          quo = num / 64'(b);
          r.value = 32'(quo);
        end
      end
      fpa_pkg::FN_GT: r.cmp = a > b;
      fpa_pkg::FN_LT: r.cmp = a < b;
      fpa_pkg::FN_GE: r.cmp = a >= b;
      fpa_pkg::FN_LE: r.cmp = a <= b;
      fpa_pkg::FN_EQ: r.cmp = a == b;
      fpa_pkg::FN_NE: r.cmp = a != b;
      fpa_pkg::FN_MIN: r.value = (a < b) ? a : b;
      fpa_pkg::FN_MAX: r.value = (b < a) ? a : b;
      fpa_pkg::FN_INC: r.value = a + 1;
      fpa_pkg::FN_DEC: r.value = a - 1;
      fpa_pkg::FN_FROM_INT: r.value = a <<< FRAC;
      default: r.value = a >>> FRAC;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] rand_operand();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'($urandom_range(0, 8)) - 4;
      3: return 32'($urandom_range(0, 4096)) - 2048;
      4: return 32'($urandom_range(0, 1)) ? 32'sh100 : -32'sh100;
      default: return $urandom();
    endcase
  endfunction

  task automatic add_vec(fpa_pkg::func_t fn, logic signed [31:0] a, logic signed [31:0] b,
                         logic known, alu_result_t res);
    vector_t v;
    v.fn = fn;
    v.a = a;
    v.b = b;
    v.known = known;
    v.res = res;
    vectors.push_back(v);
  endtask

  task automatic send_word(fpa_pkg::func_t fn, logic signed [31:0] a,
                           logic signed [31:0] b, alu_result_t res);
    in_valid <= 1'b1;
    func <= fn;
    operand_a <= a;
    operand_b <= b;
    pending_results.push_back(res);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  // Output checking.
  always @(posedge clk) begin
    alu_result_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word value=%h cmp=%b dz=%b", $time, result_value,
                 compare_true, divide_by_zero);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (result_value !== exp_r.value) begin
          $display("%0t: result_value expected %h actual %h", $time, exp_r.value,
                   result_value);
          errors++;
        end
        if (compare_true !== exp_r.cmp) begin
          $display("%0t: compare_true expected %b actual %b", $time, exp_r.cmp,
                   compare_true);
          errors++;
        end
        if (divide_by_zero !== exp_r.dz) begin
          $display("%0t: divide_by_zero expected %b actual %b", $time, exp_r.dz,
                   divide_by_zero);
          errors++;
        end
      end
    end
  end

  // Receiver stalls: alternate between free-flowing and choppy stretches.
  always @(posedge clk) begin
    int phase;
    phase = ($time / 400) % 3;
    if (phase == 0) out_ready <= 1'b1;
    else if (phase == 1) out_ready <= ($urandom_range(0, 3) != 0);
    else out_ready <= ($urandom_range(0, 2) == 0);
  end

  initial begin
    alu_result_t r;
    int burst;
    fpa_pkg::func_t fn;
    logic signed [31:0] a;
    logic signed [31:0] b;

    // Results that can be read straight off the definition.
    r = '0; r.dz = 1'b1;
    add_vec(fpa_pkg::FN_DIV, 32'sh100, 32'sh0, 1'b1, r);
    add_vec(fpa_pkg::FN_DIV, 32'sh80000000, 32'sh0, 1'b1, r);
    r = '0; r.value = 32'sh80000000;
    add_vec(fpa_pkg::FN_ADD, 32'sh7fffffff, 32'sh1, 1'b1, r);
    r = '0; r.value = 32'sh7fffffff;
    add_vec(fpa_pkg::FN_SUB, 32'sh80000000, 32'sh1, 1'b1, r);
    r = '0; r.value = 32'sh80000000;
    add_vec(fpa_pkg::FN_INC, 32'sh7fffffff, 32'sh5, 1'b1, r);
    r = '0; r.value = 32'sh7fffffff;
    add_vec(fpa_pkg::FN_DEC, 32'sh80000000, 32'sh0, 1'b1, r);
    r = '0; r.value = -32'sh1;
    add_vec(fpa_pkg::FN_TO_INT, -32'sh1, 32'sh0, 1'b1, r);
    r = '0; r.value = 32'sh100;
    add_vec(fpa_pkg::FN_MIN, 32'sh100, 32'sh100, 1'b1, r);
    add_vec(fpa_pkg::FN_MAX, 32'sh100, 32'sh100, 1'b1, r);
    r = '0; r.cmp = 1'b1;
    add_vec(fpa_pkg::FN_GE, 32'sh80000000, 32'sh80000000, 1'b1, r);
    add_vec(fpa_pkg::FN_LE, 32'sh7fffffff, 32'sh7fffffff, 1'b1, r);
    add_vec(fpa_pkg::FN_EQ, -32'sh1, -32'sh1, 1'b1, r);
    r = '0;
    // Rows checked against the predictor.
    add_vec(fpa_pkg::FN_DIV, 32'sh80000000, -32'sh100, 1'b0, r);
    add_vec(fpa_pkg::FN_DIV, 32'sh7fffffff, 32'sh1, 1'b0, r);
    add_vec(fpa_pkg::FN_DIV, -32'sh180, 32'sh200, 1'b0, r);
    add_vec(fpa_pkg::FN_MUL, 32'sh80000000, 32'sh80000000, 1'b0, r);
    add_vec(fpa_pkg::FN_MUL, 32'sh7fffffff, -32'sh1, 1'b0, r);
    add_vec(fpa_pkg::FN_GT, 32'sh7fffffff, 32'sh80000000, 1'b0, r);
    add_vec(fpa_pkg::FN_LT, 32'sh7fffffff, 32'sh80000000, 1'b0, r);
    add_vec(fpa_pkg::FN_NE, 32'sh0, 32'sh0, 1'b0, r);
    add_vec(fpa_pkg::FN_MIN, 32'sh80000000, 32'sh7fffffff, 1'b0, r);
    add_vec(fpa_pkg::FN_MAX, 32'sh80000000, 32'sh7fffffff, 1'b0, r);
    add_vec(fpa_pkg::FN_FROM_INT, 32'sh7fffffff, 32'sh0, 1'b0, r);
    add_vec(fpa_pkg::FN_TO_INT, 32'sh80000000, 32'sh0, 1'b0, r);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (vectors[i]) begin
      r = vectors[i].known ? vectors[i].res
                           : alu_predict(vectors[i].fn, vectors[i].a, vectors[i].b);
      send_word(vectors[i].fn, vectors[i].a, vectors[i].b, r);
      if ($urandom_range(0, 3) == 0) go_idle();
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);

    for (int n = 0; n < N_RANDOM; ) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && n < N_RANDOM; k++, n++) begin
        fn = fpa_pkg::func_t'($urandom_range(0, 15));
        a = rand_operand();
        b = ($urandom_range(0, 15) == 0) ? 32'sh0 : rand_operand();
        send_word(fn, a, b, alu_predict(fn, a, b));
      end
      if (n == N_RANDOM / 2) begin
        // Drain the pipeline completely if a burst ends exactly at the halfway count.
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end else if ($urandom_range(0, 3) != 0) begin
        go_idle();
      end
    end
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY * 4) @(posedge clk);
    if (errors == 0) begin
      $display("tb_fixed_point_alu_unit: PASS");
    end else begin
      $display("tb_fixed_point_alu_unit: FAIL");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("tb_fixed_point_alu_unit: FAIL");
    $finish;
  end

endmodule
